/* rtl/core/assert_macros.svh */
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge, masked while reset is high.
`define TPWE_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("tpwe assertion failed");

// Implication checked at every clock edge, including during reset.
`define TPWE_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("tpwe assertion failed");

`endif

/* rtl/core/tpwe_pkg.sv */
// Package: types, codes and helpers of the pulse width tape encoder.
package tpwe_pkg;

   localparam int unsigned PeriodWidth   = 12;
   localparam int unsigned DurationWidth = 15;
   localparam int unsigned SumWidth      = 16;
   localparam int unsigned RunIdxWidth   = 6;

   localparam logic [PeriodWidth-1:0] PeriodReset = 12'd25;

   typedef enum logic [2:0] {
      CMD_HEADER   = 3'd0,
      CMD_PAYLOAD  = 3'd1,
      CMD_CHECKSUM = 3'd2,
      CMD_SYNC     = 3'd3,
      CMD_START    = 3'd4,
      CMD_END      = 3'd5,
      CMD_ONE_BIT  = 3'd6,
      CMD_UNUSED   = 3'd7
   } cmd_type;

   typedef struct packed {
      logic                     level;
      logic [DurationWidth-1:0] duration;
      logic                     last;
   } run_type;

   // Index of the final run of a command; unused codes report zero.
   function automatic logic [RunIdxWidth-1:0] last_index(input logic [2:0] cmd);
      logic [RunIdxWidth-1:0] idx;
      idx = '0;
      case (cmd) inside
         CMD_HEADER, CMD_PAYLOAD: idx = 6'd31;
         CMD_CHECKSUM:            idx = 6'd63;
         CMD_SYNC, CMD_END:       idx = 6'd1;
         CMD_START:               idx = 6'd0;
         CMD_ONE_BIT:             idx = 6'd3;
         default:                 idx = '0;
      endcase
      return idx;
   endfunction

   function automatic logic cmd_known(input logic [2:0] cmd);
      return cmd != CMD_UNUSED;
   endfunction

endpackage

/* rtl/core/tpwe_req_if.sv */
// Request channel interface: command and data byte with valid/ready.
interface tpwe_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] cmd;
   logic [7:0] data_byte;

   modport source (output valid, output cmd, output data_byte, input ready);
   modport sink   (input valid, input cmd, input data_byte, output ready);
endinterface

/* rtl/core/tpwe_rsp_if.sv */
// Response channel interface: one tape run per transfer with valid/ready.
interface tpwe_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 level;
   logic [tpwe_pkg::DurationWidth-1:0]   duration;
   logic                                 last;

   modport source (output valid, output level, output duration, output last,
                   input ready);
   modport sink   (input valid, input level, input duration, input last,
                   output ready);
endinterface

/* rtl/core/tpwe_checksum.sv */
// End-around-carry checksum over payload bytes, cleared by the checksum request.
module tpwe_checksum (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            accept,
   input  logic [2:0]                      cmd,
   input  logic [7:0]                      data_byte,
   output logic [tpwe_pkg::SumWidth-1:0]   sum
);

   logic [tpwe_pkg::SumWidth-1:0] sum_ff;
   logic [tpwe_pkg::SumWidth-1:0] sum_in;
   logic [tpwe_pkg::SumWidth:0]   raw_sum;

   assign raw_sum = {1'b0, sum_ff} + {9'd0, data_byte};

   always_comb begin
      sum_in = sum_ff;
      if (accept) begin
         case (cmd)
            tpwe_pkg::CMD_PAYLOAD: begin
               // carry out wraps back into bit 0
               sum_in = raw_sum[16] ? raw_sum[15:0] + 16'd1 : raw_sum[15:0];
            end
            tpwe_pkg::CMD_CHECKSUM: sum_in = '0;
            default:                sum_in = sum_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else begin
         sum_ff <= sum_in;
      end
   end

   assign sum = sum_ff;

endmodule

/* rtl/core/tpwe_sequencer.sv */
// Run sequencer: holds one request and steps through its tape runs.
`include "assert_macros.svh"

module tpwe_sequencer (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              load,
   input  logic [2:0]                        load_cmd,
   input  logic [tpwe_pkg::SumWidth-1:0]     load_word,
   input  logic [tpwe_pkg::PeriodWidth-1:0]  period,
   input  logic                              out_free,
   output logic                              free,
   output logic                              advance,
   output tpwe_pkg::run_type                 run
);

   logic                                busy_ff,  busy_in;
   logic [2:0]                          cmd_ff,   cmd_in;
   logic [tpwe_pkg::SumWidth-1:0]       word_ff,  word_in;
   logic [tpwe_pkg::RunIdxWidth-1:0]    idx_ff,   idx_in;

   logic [tpwe_pkg::DurationWidth-1:0]  dur_1s;
   logic [tpwe_pkg::DurationWidth-1:0]  dur_2s;
   logic [tpwe_pkg::DurationWidth-1:0]  dur_4s;
   logic [tpwe_pkg::DurationWidth-1:0]  dur_8s;
   logic                                bit_val;
   logic                                is_last;

   assign dur_1s = {3'd0, period};
   assign dur_2s = {2'd0, period, 1'b0};
   assign dur_4s = {1'b0, period, 2'd0};
   assign dur_8s = {period, 3'd0};

   assign is_last = (idx_ff == tpwe_pkg::last_index(cmd_ff));
   assign advance = busy_ff & out_free;
   assign free    = ~busy_ff | (advance & is_last);

   // Bit being sent: four runs per bit, LSB first.
   assign bit_val = (cmd_ff == tpwe_pkg::CMD_ONE_BIT) ? 1'b1 : word_ff[idx_ff[5:2]];

   always_comb begin
      run.level    = ~idx_ff[0];
      run.duration = dur_1s;
      run.last     = is_last;
      case (cmd_ff) inside
         tpwe_pkg::CMD_HEADER, tpwe_pkg::CMD_PAYLOAD, tpwe_pkg::CMD_CHECKSUM,
         tpwe_pkg::CMD_ONE_BIT: begin
            run.duration = (bit_val & ~idx_ff[1]) ? dur_2s : dur_1s;
         end
         tpwe_pkg::CMD_SYNC:  run.duration = dur_1s;
         tpwe_pkg::CMD_START: run.duration = dur_8s;
         tpwe_pkg::CMD_END:   run.duration = dur_4s;
         default:             run.duration = dur_1s;
      endcase
   end

   always_comb begin
      busy_in = busy_ff;
      cmd_in  = cmd_ff;
      word_in = word_ff;
      idx_in  = idx_ff;
      if (advance) begin
         idx_in = idx_ff + 6'd1;
         if (is_last) begin
            busy_in = 1'b0;
         end
      end
      if (load) begin
         busy_in = 1'b1;
         cmd_in  = load_cmd;
         word_in = load_word;
         idx_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      word_ff <= word_in;
   end

   `TPWE_ASSERT(a_load_only_when_free, clock, reset, load |-> free)
   `TPWE_ASSERT(a_idx_in_range, clock, reset,
      busy_ff |-> idx_ff <= tpwe_pkg::last_index(cmd_ff))
   `TPWE_ASSERT(a_stay_busy_mid_run, clock, reset,
      (busy_ff && !(advance && is_last)) |=> busy_ff)
   `TPWE_ASSERT(a_load_restarts, clock, reset, load |=> (busy_ff && idx_ff == '0))

endmodule

/* rtl/core/tpwe_out_reg.sv */
// Output register of the response channel.
`include "assert_macros.svh"

module tpwe_out_reg (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  tpwe_pkg::run_type  run,
   output logic               free,
   tpwe_rsp_if.source         rsp_bus
);

   logic              valid_ff, valid_in;
   tpwe_pkg::run_type run_ff,   run_in;

   assign free = ~valid_ff | rsp_bus.ready;

   always_comb begin
      valid_in = valid_ff;
      run_in   = run_ff;
      if (push) begin
         valid_in = 1'b1;
         run_in   = run;
      end else if (rsp_bus.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      run_ff <= run_in;
   end

   assign rsp_bus.valid    = valid_ff;
   assign rsp_bus.level    = run_ff.level;
   assign rsp_bus.duration = run_ff.duration;
   assign rsp_bus.last     = run_ff.last;

   `TPWE_ASSERT(a_no_overwrite, clock, reset, push |-> free)
   `TPWE_ASSERT(a_push_shows, clock, reset, push |=> valid_ff)
   `TPWE_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> !valid_ff)

endmodule

/* rtl/core/tape_pulse_width_encoder.sv */
// Top level of the pulse width tape encoder.
//
// req_bus takes one command per request (cmd, data_byte) with valid/ready.
// rsp_bus gives one tape run per transfer: level, duration in ticks and
// last, set on the final run of a request.
// csr_write_en/csr_write_data set the base period S (0 acts as 1); write it
// only while the block is idle.
// Runs per request: header or payload byte 32, checksum 64, sync pair 2,
// start marker 1, end marker 2, one bit 4; code 7 is taken and dropped.
// The first run of a request shows on rsp_bus after the request is loaded into the
// run sequencer and that run moves on to the output register. Throughput: one run
// per cycle while rsp_bus does not stall; the run sequencer holds one request and
// steps one run per cycle when the output register is free, and the next request
// is taken in the cycle its last run moves on, so runs of consecutive requests follow with no gap.
// When rsp_bus stalls, the output register holds its run, the sequencer
// waits and req_bus ready stays low until the held request's last run moves.
// Reset clears the checksum, the period back to 25 and all valid state.
module tape_pulse_width_encoder (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_en,
   input  logic [tpwe_pkg::PeriodWidth-1:0]  csr_write_data,
   tpwe_req_if.sink                          req_bus,
   tpwe_rsp_if.source                        rsp_bus
);

   logic [tpwe_pkg::PeriodWidth-1:0] period_ff, period_in;
   logic [tpwe_pkg::PeriodWidth-1:0] period_eff;
   logic [tpwe_pkg::SumWidth-1:0]    sum;
   logic [tpwe_pkg::SumWidth-1:0]    load_word;
   logic                             accept;
   logic                             load;
   logic                             seq_free;
   logic                             out_free;
   logic                             advance;
   tpwe_pkg::run_type                run;

   assign period_in  = csr_write_en ? csr_write_data : period_ff;
   assign period_eff = (period_ff == '0) ? 12'd1 : period_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= tpwe_pkg::PeriodReset;
      end else begin
         period_ff <= period_in;
      end
   end

   assign req_bus.ready = seq_free;
   assign accept        = req_bus.valid & seq_free;
   assign load          = accept & tpwe_pkg::cmd_known(req_bus.cmd);
   assign load_word     = (req_bus.cmd == tpwe_pkg::CMD_CHECKSUM) ? sum
                                                                  : {8'd0, req_bus.data_byte};

   tpwe_checksum u_checksum (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .cmd       (req_bus.cmd),
      .data_byte (req_bus.data_byte),
      .sum       (sum)
   );

   tpwe_sequencer u_sequencer (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .load_cmd  (req_bus.cmd),
      .load_word (load_word),
      .period    (period_eff),
      .out_free  (out_free),
      .free      (seq_free),
      .advance   (advance),
      .run       (run)
   );

   tpwe_out_reg u_out_reg (
      .clock   (clock),
      .reset   (reset),
      .push    (advance),
      .run     (run),
      .free    (out_free),
      .rsp_bus (rsp_bus)
   );

endmodule
